### sv/swpc_pkg.sv
// Shared types and constants for the square window point count core.
// No dependencies; imported by the cell and the top level.
package swpc_pkg;

   localparam int MAX_POINTS_DEFAULT = 256;
   localparam int COORD_BITS_DEFAULT = 16;
   localparam int HALF_BITS          = 16;

   typedef enum logic [1:0] {
      OP_LOAD  = 2'd0,
      OP_QUERY = 2'd1,
      OP_CLEAR = 2'd2
   } op_type;

   // Control part of an item travelling down the cell chain.
   typedef struct packed {
      logic   valid;
      op_type op;
      logic   dropped;
   } token_ctrl_type;

endpackage

### sv/swpc_cell.sv
// One point cell of the chain: holds one stored point and its valid bit,
// and passes each item on to the next cell through its registers while advance is high. Uses swpc_pkg.
module swpc_cell #(
   parameter int INDEX      = 0,
   parameter int COORD_BITS = swpc_pkg::COORD_BITS_DEFAULT,
   parameter int COUNT_BITS = 9
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       advance,
   input  swpc_pkg::token_ctrl_type   ctrl_in,
   input  logic signed [COORD_BITS-1:0] x_in,
   input  logic signed [COORD_BITS-1:0] y_in,
   input  logic [swpc_pkg::HALF_BITS-1:0] hw_in,
   input  logic [COUNT_BITS-1:0]      count_in,
   output swpc_pkg::token_ctrl_type   ctrl_out,
   output logic signed [COORD_BITS-1:0] x_out,
   output logic signed [COORD_BITS-1:0] y_out,
   output logic [swpc_pkg::HALF_BITS-1:0] hw_out,
   output logic [COUNT_BITS-1:0]      count_out
);
   import swpc_pkg::*;

   localparam int MAG_BITS = COORD_BITS + 1;
   localparam int CMP_BITS = (MAG_BITS > HALF_BITS) ? MAG_BITS : HALF_BITS;
   // A load lands here when the count after it equals this slot number plus one.
   localparam logic [COUNT_BITS-1:0] SLOT = COUNT_BITS'(INDEX + 1);

   logic signed [COORD_BITS-1:0] px_ff, py_ff;
   logic                         held_ff;
   logic                         ctrl_valid_ff;
   op_type                       ctrl_op_ff;
   logic                         ctrl_dropped_ff;
   logic signed [COORD_BITS-1:0] x_ff, y_ff;
   logic [HALF_BITS-1:0]         hw_ff;
   logic [COUNT_BITS-1:0]        count_ff;

   logic [MAG_BITS-1:0] dx, dy, mx, my;
   logic                in_window, store_here;
   logic [COUNT_BITS-1:0] count_in_next;

   always_comb begin
      dx = {px_ff[COORD_BITS-1], px_ff} - {x_in[COORD_BITS-1], x_in};
      dy = {py_ff[COORD_BITS-1], py_ff} - {y_in[COORD_BITS-1], y_in};
      mx = dx[MAG_BITS-1] ? (~dx + MAG_BITS'(1)) : dx;
      my = dy[MAG_BITS-1] ? (~dy + MAG_BITS'(1)) : dy;
      in_window = (CMP_BITS'(mx) <= CMP_BITS'(hw_in)) && (CMP_BITS'(my) <= CMP_BITS'(hw_in));
      store_here = ctrl_in.valid && (ctrl_in.op == OP_LOAD) && !ctrl_in.dropped
                   && (count_in == SLOT);
      count_in_next = count_in;
      if (ctrl_in.valid && (ctrl_in.op == OP_QUERY) && held_ff && in_window) begin
         count_in_next = count_in + COUNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff       <= 1'b0;
         ctrl_valid_ff <= 1'b0;
      end else if (advance) begin
         ctrl_valid_ff <= ctrl_in.valid;
         if (store_here) begin
            held_ff <= 1'b1;
         end else if (ctrl_in.valid && (ctrl_in.op == OP_CLEAR)) begin
            held_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         ctrl_op_ff      <= ctrl_in.op;
         ctrl_dropped_ff <= ctrl_in.dropped;
         x_ff            <= x_in;
         y_ff            <= y_in;
         hw_ff           <= hw_in;
         count_ff        <= count_in_next;
         if (store_here) begin
            px_ff <= x_in;
            py_ff <= y_in;
         end
      end
   end

   always_comb begin
      ctrl_out.valid   = ctrl_valid_ff;
      ctrl_out.op      = ctrl_op_ff;
      ctrl_out.dropped = ctrl_dropped_ff;
   end

   assign x_out     = x_ff;
   assign y_out     = y_ff;
   assign hw_out    = hw_ff;
   assign count_out = count_ff;

endmodule

### sv/square_window_point_count_core.sv
// Square window point count: a chain of MAX_POINTS point cells, one stored point each.
// An item passes through the registers of every cell in order, then the output register.
// Throughput: one item per cycle, set by the cell chain stepping once per cycle; the chain
// holds only while a result waits and the chain end is full.
// Reset: synchronous; clears the fill counter, all cell valid bits and all valid flags.
// Point storage needs no clearing pass.
// Depends on swpc_pkg and swpc_cell.
module square_window_point_count_core #(
   parameter int MAX_POINTS = swpc_pkg::MAX_POINTS_DEFAULT,
   parameter int COORD_BITS = swpc_pkg::COORD_BITS_DEFAULT,
   localparam int COUNT_BITS = $clog2(MAX_POINTS + 1),
   localparam int REQ_BITS   = ((2 * COORD_BITS + swpc_pkg::HALF_BITS + 7) / 8) * 8,
   localparam int RSP_BITS   = ((COUNT_BITS + 7) / 8) * 8
) (
   input  logic                clock,
   input  logic                reset,
   // req_tdata: coord_x, coord_y, half_width from the lowest bit up; zero padding above
   input  logic [REQ_BITS-1:0] req_tdata,
   // req_tuser: operation
   input  logic [1:0]          req_tuser,
   input  logic                req_tvalid,
   output logic                req_tready,
   // rsp_tdata: count; zero padding above
   output logic [RSP_BITS-1:0] rsp_tdata,
   // rsp_tuser: dropped
   output logic                rsp_tuser,
   output logic                rsp_tvalid,
   input  logic                rsp_tready
);
   import swpc_pkg::*;

   localparam logic [COUNT_BITS-1:0] FULL = COUNT_BITS'(MAX_POINTS);

   // Chain links: link 0 is the incoming item, link MAX_POINTS leaves the last cell.
   token_ctrl_type               link_ctrl  [MAX_POINTS+1];
   logic signed [COORD_BITS-1:0] link_x     [MAX_POINTS+1];
   logic signed [COORD_BITS-1:0] link_y     [MAX_POINTS+1];
   logic [HALF_BITS-1:0]         link_hw    [MAX_POINTS+1];
   logic [COUNT_BITS-1:0]        link_count [MAX_POINTS+1];

   logic [COUNT_BITS-1:0] held_ff, held_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [COUNT_BITS-1:0] rsp_count_ff, rsp_count_in;
   logic                  rsp_dropped_ff, rsp_dropped_in;
   logic                  out_free, advance, accept;
   op_type                req_op;
   token_ctrl_type        entry_ctrl;
   logic [COUNT_BITS-1:0] entry_count;

   // The output register frees when empty or taken; the chain steps unless
   // its last cell holds an item that has nowhere to go.
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign advance    = !link_ctrl[MAX_POINTS].valid || out_free;
   assign req_tready = advance;
   assign accept     = req_tvalid && advance;
   assign req_op     = op_type'(req_tuser);

   // Entry: track the fill level and stamp each item with its result count.
   // Loads and clears get their final count here; a query starts at zero and gathers hits.
   always_comb begin
      held_in            = held_ff;
      entry_ctrl.valid   = req_tvalid;
      entry_ctrl.op      = req_op;
      entry_ctrl.dropped = 1'b0;
      entry_count        = held_ff;
      unique case (req_op)
         OP_LOAD: begin
            if (held_ff < FULL) begin
               held_in     = held_ff + COUNT_BITS'(1);
               entry_count = held_ff + COUNT_BITS'(1);
            end else begin
               entry_ctrl.dropped = 1'b1;
            end
         end
         OP_QUERY: begin
            entry_count = '0;
         end
         OP_CLEAR: begin
            held_in     = '0;
            entry_count = '0;
         end
         default: begin
            // unused code: report the fill level, change nothing
         end
      endcase
   end

   assign link_ctrl[0]  = entry_ctrl;
   assign link_x[0]     = req_tdata[COORD_BITS-1:0];
   assign link_y[0]     = req_tdata[2*COORD_BITS-1:COORD_BITS];
   assign link_hw[0]    = req_tdata[2*COORD_BITS+HALF_BITS-1:2*COORD_BITS];
   assign link_count[0] = entry_count;

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff <= '0;
      end else if (accept) begin
         held_ff <= held_in;
      end
   end

   // Row of point cells; each item visits every cell in order, so a load or
   // clear takes effect exactly for the items behind it.
   for (genvar i = 0; i < MAX_POINTS; i++) begin : g_cell
      swpc_cell #(
         .INDEX      (i),
         .COORD_BITS (COORD_BITS),
         .COUNT_BITS (COUNT_BITS)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .ctrl_in   (link_ctrl[i]),
         .x_in      (link_x[i]),
         .y_in      (link_y[i]),
         .hw_in     (link_hw[i]),
         .count_in  (link_count[i]),
         .ctrl_out  (link_ctrl[i+1]),
         .x_out     (link_x[i+1]),
         .y_out     (link_y[i+1]),
         .hw_out    (link_hw[i+1]),
         .count_out (link_count[i+1])
      );
   end

   // Output register: take the chain's last item whenever the slot is free.
   always_comb begin
      rsp_valid_in   = rsp_valid_ff;
      rsp_count_in   = rsp_count_ff;
      rsp_dropped_in = rsp_dropped_ff;
      if (out_free) begin
         rsp_valid_in   = link_ctrl[MAX_POINTS].valid;
         rsp_count_in   = link_count[MAX_POINTS];
         rsp_dropped_in = link_ctrl[MAX_POINTS].dropped;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_count_ff   <= rsp_count_in;
      rsp_dropped_ff <= rsp_dropped_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_BITS'(rsp_count_ff);
   assign rsp_tuser  = rsp_dropped_ff;

endmodule
